// ----- hdl/cpa_pkg.sv -----
// shared constants, types and codes for the color pulse animator
// no dependencies; used by cpa_ctrl, cpa_dp and color_pulse_animator
`timescale 1ns / 1ps

package cpa_pkg;

  // table geometry
  localparam int ENTRIES = 16;
  localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // field widths
  localparam int IDX_W   = 4;
  localparam int COLOR_W = 24;
  localparam int CH_W    = 8;
  localparam int IV_W    = 10;
  localparam int NUM_CH  = 3;
  localparam int CHS_W   = 2;

  // fade divider: product width, quotient bits per cycle, cycle count
  localparam int PROD_W     = IV_W + CH_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = (PROD_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  // command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // full-scale channel value
  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEP,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } cpa_state_t;

  // controller to datapath
  typedef struct packed {
    logic             set_wr;
    logic             step;
    logic             mul_load;
    logic             div_step;
    logic             div_last;
    logic             emit;
    logic [ENT_W-1:0] idx;
    logic [CHS_W-1:0] ch;
  } cpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pulsing;
    logic more_after;
    logic out_free;
  } cpa_status_t;

endpackage

// ----- hdl/cpa_ctrl.sv -----
// controller for the color pulse animator: sequences the table scan,
// phase step, per-channel multiply and divide, and result hand-off
// depends on cpa_pkg
`timescale 1ns / 1ps

module cpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_stall,
  output cpa_pkg::cpa_cmd_t    cmd,
  input  cpa_pkg::cpa_status_t stat
);

  localparam logic [cpa_pkg::ENT_W-1:0] IDX_LAST = cpa_pkg::ENT_W'(cpa_pkg::ENTRIES - 1);
  localparam logic [cpa_pkg::CNT_W-1:0] CNT_LAST = cpa_pkg::CNT_W'(cpa_pkg::DIV_CYCLES - 1);
  localparam logic [cpa_pkg::CHS_W-1:0] CH_LAST  = cpa_pkg::CHS_W'(cpa_pkg::NUM_CH - 1);

  cpa_pkg::cpa_state_t state_r, state_nxt;
  logic [cpa_pkg::ENT_W-1:0] idx_r, idx_nxt;
  logic [cpa_pkg::CHS_W-1:0] ch_r, ch_nxt;
  logic [cpa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpa_pkg::ST_IDLE;
      idx_r   <= '0;
      ch_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      cpa_pkg::ST_IDLE: begin
        if (in_valid && in_command == cpa_pkg::CMD_TICK) begin
          state_nxt = cpa_pkg::ST_SCAN;
          idx_nxt   = '0;
        end
      end
      cpa_pkg::ST_SCAN: begin
        if (stat.pulsing) begin
          state_nxt = cpa_pkg::ST_STEP;
        end else if (idx_r == IDX_LAST) begin
          state_nxt = cpa_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      cpa_pkg::ST_STEP: begin
        state_nxt = cpa_pkg::ST_MUL;
        ch_nxt    = '0;
      end
      cpa_pkg::ST_MUL: begin
        state_nxt = cpa_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      cpa_pkg::ST_DIV: begin
        if (cnt_r == CNT_LAST) begin
          if (ch_r == CH_LAST) begin
            state_nxt = cpa_pkg::ST_EMIT;
          end else begin
            state_nxt = cpa_pkg::ST_MUL;
            ch_nxt    = ch_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      cpa_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          if (stat.more_after) begin
            state_nxt = cpa_pkg::ST_SCAN;
            idx_nxt   = idx_r + 1'b1;
          end else begin
            state_nxt = cpa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = cpa_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    in_stall     = (state_r != cpa_pkg::ST_IDLE);
    cmd.set_wr   = (state_r == cpa_pkg::ST_IDLE) && in_valid &&
                   (in_command == cpa_pkg::CMD_SET);
    cmd.step     = (state_r == cpa_pkg::ST_STEP);
    cmd.mul_load = (state_r == cpa_pkg::ST_MUL);
    cmd.div_step = (state_r == cpa_pkg::ST_DIV);
    cmd.div_last = (state_r == cpa_pkg::ST_DIV) && (cnt_r == CNT_LAST);
    cmd.emit     = (state_r == cpa_pkg::ST_EMIT) && stat.out_free;
    cmd.idx      = idx_r;
    cmd.ch       = ch_r;
  end

  // a tick transaction starts the scan at the first entry
  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command == cpa_pkg::CMD_TICK) |=>
    (state_r == cpa_pkg::ST_SCAN && idx_r == '0))
    else $error("tick did not start scan at entry zero");

  // divider count stays within its cycle budget
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpa_pkg::ST_DIV) |-> (cnt_r <= CNT_LAST))
    else $error("divider count out of range");

  // channel select stays on a real channel while fading
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpa_pkg::ST_MUL || state_r == cpa_pkg::ST_DIV) |-> (ch_r <= CH_LAST))
    else $error("channel select out of range");

endmodule

// ----- hdl/cpa_dp.sv -----
// datapath for the color pulse animator: entry tables, phase step,
// fade multiplier, shared two-bit-per-cycle divider and output register
// depends on cpa_pkg
`timescale 1ns / 1ps

module cpa_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cpa_pkg::IDX_W-1:0]         in_entry_index,
  input  logic [cpa_pkg::COLOR_W-1:0]       in_original_color,
  input  logic [cpa_pkg::IV_W-1:0]          in_pulse_interval,
  input  cpa_pkg::cpa_cmd_t                 cmd,
  output cpa_pkg::cpa_status_t              stat,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cpa_pkg::IDX_W-1:0]         out_index,
  output logic [cpa_pkg::COLOR_W-1:0]       out_animated_color,
  output logic                              out_last_of_tick
);

  // entry tables
  logic [cpa_pkg::COLOR_W-1:0] colors_r    [cpa_pkg::ENTRIES];
  logic [cpa_pkg::IV_W-1:0]    intervals_r [cpa_pkg::ENTRIES];
  logic [cpa_pkg::IV_W-1:0]    phases_r    [cpa_pkg::ENTRIES];
  logic                        rising_r    [cpa_pkg::ENTRIES];

  // working entry
  logic [cpa_pkg::COLOR_W-1:0] cur_color_r;
  logic [cpa_pkg::IV_W-1:0]    cur_iv_r;
  logic [cpa_pkg::IV_W-1:0]    cur_t_r;

  // divider state: dividend shifts out, quotient shifts in
  logic [cpa_pkg::PROD_W-1:0]  dq_r;
  logic [cpa_pkg::IV_W-1:0]    rem_r;
  logic [cpa_pkg::COLOR_W-1:0] res_r;

  // output register
  logic                        out_valid_r;
  logic [cpa_pkg::IDX_W-1:0]   out_index_r;
  logic [cpa_pkg::COLOR_W-1:0] out_color_r;
  logic                        out_last_r;

  logic                        set_ok;
  logic [cpa_pkg::ENT_W-1:0]   set_idx;
  logic [cpa_pkg::IV_W-1:0]    sel_iv;
  logic [cpa_pkg::IV_W-1:0]    sel_phase;
  logic                        sel_rising;
  logic [cpa_pkg::IV_W-1:0]    step_phase;
  logic                        step_rising;
  logic [cpa_pkg::IV_W-1:0]    step_t;
  logic                        more_after;
  logic [cpa_pkg::CH_W-1:0]    c_ch;
  logic [cpa_pkg::PROD_W-1:0]  prod;
  logic [cpa_pkg::PROD_W-1:0]  dq_v;
  logic [cpa_pkg::IV_W-1:0]    rem_v;
  logic [cpa_pkg::CH_W-1:0]    sum_byte;

  // set decode
  assign set_ok  = cmd.set_wr && (int'(in_entry_index) < cpa_pkg::ENTRIES);
  assign set_idx = cpa_pkg::ENT_W'(in_entry_index);

  // selected entry
  assign sel_iv     = intervals_r[cmd.idx];
  assign sel_phase  = phases_r[cmd.idx];
  assign sel_rising = rising_r[cmd.idx];

  // triangle wave step
  always_comb begin
    step_phase  = sel_phase;
    step_rising = sel_rising;
    if (sel_rising) begin
      if (sel_phase == sel_iv) begin
        step_rising = 1'b0;
        step_phase  = sel_phase - 1'b1;
      end else begin
        step_phase  = sel_phase + 1'b1;
      end
    end else begin
      if (sel_phase == '0) begin
        step_rising = 1'b1;
        step_phase  = cpa_pkg::IV_W'(1);
      end else begin
        step_phase  = sel_phase - 1'b1;
      end
    end
  end

  // fade term is clamped to the interval
  assign step_t = (step_phase > sel_iv) ? sel_iv : step_phase;

  // any pulsing entry above the current one
  always_comb begin
    more_after = 1'b0;
    for (int j = 0; j < cpa_pkg::ENTRIES; j++) begin
      if (j > int'(cmd.idx) && intervals_r[j] != '0) begin
        more_after = 1'b1;
      end
    end
  end

  // channel select
  always_comb begin
    case (cmd.ch)
      2'd0:    c_ch = cur_color_r[7:0];
      2'd1:    c_ch = cur_color_r[15:8];
      2'd2:    c_ch = cur_color_r[23:16];
      default: c_ch = cur_color_r[7:0];
    endcase
  end

  // fade numerator
  assign prod = cpa_pkg::PROD_W'(cur_t_r) * cpa_pkg::PROD_W'(cpa_pkg::CH_MAX - c_ch);

  // restoring divide, two quotient bits per cycle
  always_comb begin
    logic [cpa_pkg::IV_W:0] sh;
    dq_v  = dq_r;
    rem_v = rem_r;
    for (int s = 0; s < cpa_pkg::DIV_STEPS; s++) begin
      sh   = {rem_v, dq_v[cpa_pkg::PROD_W-1]};
      dq_v = {dq_v[cpa_pkg::PROD_W-2:0], 1'b0};
      if (sh >= {1'b0, cur_iv_r}) begin
        rem_v   = cpa_pkg::IV_W'(sh - {1'b0, cur_iv_r});
        dq_v[0] = 1'b1;
      end else begin
        rem_v = sh[cpa_pkg::IV_W-1:0];
      end
    end
  end

  assign sum_byte = c_ch + dq_v[cpa_pkg::CH_W-1:0];

  // status
  assign stat.pulsing    = (sel_iv != '0);
  assign stat.more_after = more_after;
  assign stat.out_free   = !out_valid_r || !out_stall;

  // interval, phase and direction tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cpa_pkg::ENTRIES; i++) begin
        intervals_r[i] <= '0;
        phases_r[i]    <= '0;
        rising_r[i]    <= 1'b1;
      end
    end else if (set_ok) begin
      intervals_r[set_idx] <= in_pulse_interval;
      phases_r[set_idx]    <= '0;
    end else if (cmd.step) begin
      phases_r[cmd.idx] <= step_phase;
      rising_r[cmd.idx] <= step_rising;
    end
  end

  // color table
  always_ff @(posedge clk) begin
    if (set_ok) begin
      colors_r[set_idx] <= in_original_color;
    end
  end

  // working entry, divider and result assembly
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      cur_color_r <= colors_r[cmd.idx];
      cur_iv_r    <= sel_iv;
      cur_t_r     <= step_t;
    end
    if (cmd.mul_load) begin
      dq_r  <= prod;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r  <= dq_v;
      rem_r <= rem_v;
    end
    if (cmd.div_last) begin
      case (cmd.ch)
        2'd0:    res_r[7:0]   <= sum_byte;
        2'd1:    res_r[15:8]  <= sum_byte;
        2'd2:    res_r[23:16] <= sum_byte;
        default: res_r[7:0]   <= sum_byte;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index_r <= cpa_pkg::IDX_W'(cmd.idx);
      out_color_r <= res_r;
      out_last_r  <= !more_after;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_index          = out_index_r;
  assign out_animated_color = out_color_r;
  assign out_last_of_tick   = out_last_r;

  // stepped phase stays on the triangle between zero and the interval
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (step_phase <= sel_iv))
    else $error("stepped phase above interval");

  // faded channel never wraps below its base value
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |-> (sum_byte >= c_ch))
    else $error("faded channel wrapped");

endmodule

// ----- hdl/color_pulse_animator.sv -----
// a set transaction is accepted only while idle
// a tick scans every entry in turn; for each pulsing entry it steps the phase,
// then per channel does a multiply and a divide on the shared divider,
// then hands the result off, waiting there while the output is stalled
// reset: synchronous active low; intervals and phases cleared, directions rising
`timescale 1ns / 1ps

module color_pulse_animator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [cpa_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [cpa_pkg::COLOR_W-1:0]  in_original_color,
  input  logic [cpa_pkg::IV_W-1:0]     in_pulse_interval,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cpa_pkg::IDX_W-1:0]    out_index,
  output logic [cpa_pkg::COLOR_W-1:0]  out_animated_color,
  output logic                         out_last_of_tick
);

  cpa_pkg::cpa_cmd_t    cmd;
  cpa_pkg::cpa_status_t stat;

  // sequencer
  cpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  // tables, arithmetic and output register
  cpa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_entry_index     (in_entry_index),
    .in_original_color  (in_original_color),
    .in_pulse_interval  (in_pulse_interval),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_index          (out_index),
    .out_animated_color (out_animated_color),
    .out_last_of_tick   (out_last_of_tick)
  );

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for color_pulse_animator: set and tick transactions in,
// predicted faded colors compared field by field with the result channel
// depends on hdl/cpa_pkg.sv and hdl/color_pulse_animator.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic                         command;
    logic [cpa_pkg::IDX_W-1:0]    entry_index;
    logic [cpa_pkg::COLOR_W-1:0]  original_color;
    logic [cpa_pkg::IV_W-1:0]     pulse_interval;
    bit                           drain_first;
  } anim_cmd_t;

  typedef struct {
    logic [cpa_pkg::IDX_W-1:0]    index;
    logic [cpa_pkg::COLOR_W-1:0]  color;
    logic                         last;
  } faded_color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_command = cpa_pkg::CMD_SET;
  logic [cpa_pkg::IDX_W-1:0]    in_entry_index = '0;
  logic [cpa_pkg::COLOR_W-1:0]  in_original_color = '0;
  logic [cpa_pkg::IV_W-1:0]     in_pulse_interval = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [cpa_pkg::IDX_W-1:0]    out_index;
  logic [cpa_pkg::COLOR_W-1:0]  out_animated_color;
  logic                         out_last_of_tick;

  // commands waiting to go out, faded colors still owed by the block
  anim_cmd_t    cmd_queue[$];
  faded_color_t faded_queue[$];
  anim_cmd_t    held_cmd;
  int           total_cmds = 0;
  int           sent_cmds = 0;
  int           err_count = 0;

  // shadow copy of the entry table
  logic [cpa_pkg::COLOR_W-1:0] base_tab [cpa_pkg::ENTRIES];
  logic [cpa_pkg::IV_W-1:0]    span_tab [cpa_pkg::ENTRIES];
  logic [cpa_pkg::IV_W-1:0]    phase_tab[cpa_pkg::ENTRIES];
  logic                        up_tab   [cpa_pkg::ENTRIES];

  color_pulse_animator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_entry_index     (in_entry_index),
    .in_original_color  (in_original_color),
    .in_pulse_interval  (in_pulse_interval),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_index          (out_index),
    .out_animated_color (out_animated_color),
    .out_last_of_tick   (out_last_of_tick)
  );

  always #1 clk = ~clk;

  // idle percentages per third of the run: sender light first, then receiver light, then none
  function automatic int idle_pct(int n, bit receiver);
    int third;
    third = (n < total_cmds / 3) ? 0 : (n < (2 * total_cmds) / 3) ? 1 : 2;
    case (third)
      0: return receiver ? 45 : 8;
      1: return receiver ? 8 : 45;
      default: return 0;
    endcase
  endfunction

  // one channel moved toward white, exact integer form
  function automatic logic [cpa_pkg::CH_W-1:0] whiten(logic [cpa_pkg::CH_W-1:0] c,
                                                     logic [cpa_pkg::IV_W-1:0] t,
                                                     logic [cpa_pkg::IV_W-1:0] span);
    logic [cpa_pkg::PROD_W-1:0] prod;
    logic [cpa_pkg::IV_W-1:0]   tc;
    if (span == '0) return c;
    tc = (t > span) ? span : t;
    prod = cpa_pkg::PROD_W'(tc) * cpa_pkg::PROD_W'(cpa_pkg::CH_MAX - c);
    return c + cpa_pkg::CH_W'(prod / cpa_pkg::PROD_W'(span));
  endfunction

  // apply one accepted transaction to the shadow table, queue owed colors
  task automatic apply_cmd(anim_cmd_t c);
    int                       pulsing;
    int                       k;
    faded_color_t             f;
    logic [cpa_pkg::IV_W-1:0] t;
    if (c.command == cpa_pkg::CMD_SET) begin
      if (int'(c.entry_index) < cpa_pkg::ENTRIES) begin
        base_tab[c.entry_index]  = c.original_color;
        span_tab[c.entry_index]  = c.pulse_interval;
        phase_tab[c.entry_index] = '0;
      end
      return;
    end
    pulsing = 0;
    for (int i = 0; i < cpa_pkg::ENTRIES; i++) if (span_tab[i] != '0) pulsing++;
    k = 0;
    for (int i = 0; i < cpa_pkg::ENTRIES; i++) begin
      if (span_tab[i] != '0) begin
        t = phase_tab[i];
        // triangle walk between 0 and the interval
        if (up_tab[i]) begin
          if (t == span_tab[i]) begin
            up_tab[i] = 1'b0;
            t = t - 1'b1;
          end else begin
            t = t + 1'b1;
          end
        end else begin
          if (t == '0) begin
            up_tab[i] = 1'b1;
            t = cpa_pkg::IV_W'(1);
          end else begin
            t = t - 1'b1;
          end
        end
        phase_tab[i] = t;
        k++;
        f.index = i[cpa_pkg::IDX_W-1:0];
        f.color = {whiten(base_tab[i][23:16], t, span_tab[i]),
                   whiten(base_tab[i][15:8], t, span_tab[i]),
                   whiten(base_tab[i][7:0], t, span_tab[i])};
        f.last  = (k == pulsing);
        faded_queue.push_back(f);
      end
    end
  endtask

  task automatic add_cmd(logic command, int idx, logic [cpa_pkg::COLOR_W-1:0] color,
                         int span, bit drain);
    anim_cmd_t c;
    c.command        = command;
    c.entry_index    = idx[cpa_pkg::IDX_W-1:0];
    c.original_color = color;
    c.pulse_interval = span[cpa_pkg::IV_W-1:0];
    c.drain_first    = drain;
    cmd_queue.push_back(c);
  endtask

  // driver: presents queued transactions, holds them while stalled
  always @(posedge clk) begin : drive_proc
    anim_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_cmd(held_cmd);
        sent_cmds <= sent_cmds + 1;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() != 0 && !(cmd_queue[0].drain_first && faded_queue.size() != 0)
            && $urandom_range(0, 99) >= idle_pct(sent_cmds, 1'b0)) begin
          nxt = cmd_queue.pop_front();
          held_cmd <= nxt;
          in_valid <= 1'b1;
          in_command <= nxt.command;
          in_entry_index <= nxt.entry_index;
          in_original_color <= nxt.original_color;
          in_pulse_interval <= nxt.pulse_interval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest owed color
  always @(posedge clk) begin : check_proc
    faded_color_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (faded_queue.size() == 0) begin
          err_count++;
          $error("unexpected result: index %0d color %06h", out_index, out_animated_color);
        end else begin
          want = faded_queue.pop_front();
          if (out_index !== want.index) begin
            err_count++;
            $error("out_index: expected %0d, got %0d", want.index, out_index);
          end
          if (out_animated_color !== want.color) begin
            err_count++;
            $error("out_animated_color: expected %06h, got %06h", want.color,
                   out_animated_color);
          end
          if (out_last_of_tick !== want.last) begin
            err_count++;
            $error("out_last_of_tick: expected %0d, got %0d", want.last, out_last_of_tick);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct(sent_cmds, 1'b1));
    end
  end

  // stimulus, reset and end of run
  initial begin
    int r;
    int span;
    for (int i = 0; i < cpa_pkg::ENTRIES; i++) begin
      base_tab[i]  = '0;
      span_tab[i]  = '0;
      phase_tab[i] = '0;
      up_tab[i]    = 1'b1;
    end

    // directed: empty tick, color and interval extremes, turning points
    add_cmd(cpa_pkg::CMD_TICK, 0, 24'h000000, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_SET, 0, 24'h000000, 1, 1'b0);
    add_cmd(cpa_pkg::CMD_SET, 15, 24'hFFFFFF, 1023, 1'b0);
    add_cmd(cpa_pkg::CMD_SET, 8, 24'h00FF00, 2, 1'b0);
    add_cmd(cpa_pkg::CMD_SET, 3, 24'hAA55C3, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_TICK, 0, 24'h000000, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_TICK, 0, 24'h000000, 0, 1'b0);
    // entry 0 is now falling at phase 0; a set keeps the direction
    add_cmd(cpa_pkg::CMD_SET, 0, 24'hFF0000, 1, 1'b0);
    add_cmd(cpa_pkg::CMD_TICK, 15, 24'hFFFFFF, 1023, 1'b0);
    add_cmd(cpa_pkg::CMD_TICK, 0, 24'h000000, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_TICK, 0, 24'h000000, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_SET, 9, 24'h7F7F7F, 512, 1'b0);
    add_cmd(cpa_pkg::CMD_SET, 10, 24'h01FE80, 1023, 1'b0);
    add_cmd(cpa_pkg::CMD_TICK, 0, 24'h000000, 0, 1'b0);
    // stop pulsing on entries that were running
    add_cmd(cpa_pkg::CMD_SET, 15, 24'h123456, 0, 1'b1);
    add_cmd(cpa_pkg::CMD_SET, 0, 24'hFFFFFF, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_TICK, 0, 24'h000000, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_SET, 8, 24'h000000, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_SET, 9, 24'h000000, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_SET, 10, 24'h000000, 0, 1'b0);
    add_cmd(cpa_pkg::CMD_TICK, 0, 24'h000000, 0, 1'b1);
    add_cmd(cpa_pkg::CMD_SET, 5, 24'h808080, 3, 1'b0);
    add_cmd(cpa_pkg::CMD_TICK, 0, 24'h000000, 0, 1'b0);

    // random: mostly short intervals so the triangle turns often
    for (int n = 0; n < 388; n++) begin
      r = $urandom_range(0, 99);
      if (r < 10) span = 0;
      else if (r < 75) span = $urandom_range(1, 6);
      else span = $urandom_range(0, 1023);
      if ($urandom_range(0, 99) < 42)
        add_cmd(cpa_pkg::CMD_TICK, $urandom_range(0, 15), cpa_pkg::COLOR_W'($urandom()),
                $urandom_range(0, 1023), $urandom_range(0, 99) < 3);
      else
        add_cmd(cpa_pkg::CMD_SET, $urandom_range(0, 15), cpa_pkg::COLOR_W'($urandom()),
                span, 1'b0);
    end
    total_cmds = cmd_queue.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_valid || faded_queue.size() != 0) @(posedge clk);
    // room for a last tick that owes nothing
    repeat (600) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/cpa_pkg.sv
hdl/cpa_ctrl.sv
hdl/cpa_dp.sv
hdl/color_pulse_animator.sv
bench/testbench.sv
